>>> rtl/core/resp_array_parser_unit_macros.svh
// Assertion macros shared by the parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RESP_ARRAY_PARSER_UNIT_MACROS_SVH
`define RESP_ARRAY_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RAPU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RAPU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rapu_pkg.sv
// Shared types and constants for the array request parser.
// No dependencies; used by rapu_front, rapu_fifo, rapu_back and the top level.
`timescale 1ns / 1ps

package rapu_pkg;

    // Limits fixed at build time
    localparam logic [5:0]  ARG_LIMIT    = 6'd32;
    localparam logic [16:0] LENGTH_LIMIT = 17'd8192;
    localparam logic [16:0] NUM_MAX      = 17'd131071;

    // Configuration reset values
    localparam logic [5:0]  MAX_ARGS_RST = 6'd32;
    localparam logic [15:0] MAX_LEN_RST  = 16'd8191;

    // Byte queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Framing characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [0:0] {
        CFG_MAX_ARGS = 1'b0,
        CFG_MAX_LEN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_HDR     = 4'd0,
        PH_CNT     = 4'd1,
        PH_CNT_LF  = 4'd2,
        PH_DOLLAR  = 4'd3,
        PH_LEN     = 4'd4,
        PH_LEN_LF  = 4'd5,
        PH_DATA    = 4'd6,
        PH_DATA_CR = 4'd7,
        PH_DATA_LF = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        RK_PAYLOAD = 2'd0,
        RK_ARG_END = 2'd1,
        RK_ERROR   = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_BAD_HEADER = 3'd0,
        ERR_NON_DIGIT  = 3'd1,
        ERR_TOO_MANY   = 3'd2,
        ERR_TOO_LONG   = 3'd3,
        ERR_BAD_TERM   = 3'd4,
        ERR_NO_DOLLAR  = 3'd5
    } err_code_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_star;
        logic       is_dollar;
    } token_t;

    // Limits in force, from the configuration registers
    typedef struct packed {
        logic [5:0]  args_limit;
        logic [15:0] max_len;
    } cfg_t;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   data_byte;
        logic [4:0]   arg_index;
        logic [15:0]  arg_length;
        logic         last;
        err_code_t    code;
    } result_t;

endpackage

>>> rtl/core/rapu_in_if.sv
// Request byte channel: valid/ready handshake carrying one raw byte per beat.
// No dependencies.
`timescale 1ns / 1ps

interface rapu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/rapu_out_if.sv
// Parse result channel: valid/ready handshake carrying one result per beat.
// No dependencies.
`timescale 1ns / 1ps

interface rapu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [4:0]  arg_index;
    logic [15:0] arg_length;
    logic        last_of_command;
    logic [2:0]  error_code;

    modport source (output valid, output result_kind, output data_byte, output arg_index,
                    output arg_length, output last_of_command, output error_code,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte, input arg_index,
                    input arg_length, input last_of_command, input error_code,
                    output ready);
endinterface

>>> rtl/core/rapu_front.sv
// Front stage: accepts request beats and classifies each byte into a token.
// Depends on rapu_pkg and rapu_in_if.
`timescale 1ns / 1ps

module rapu_front (
    input  logic              clk,
    input  logic              rst_n,
    rapu_in_if.sink           req,
    output logic              tok_valid,
    output rapu_pkg::token_t  tok,
    input  logic              tok_ready
);

    logic              valid_reg;
    rapu_pkg::token_t  tok_reg;
    rapu_pkg::token_t  tok_next;
    logic              take;

    // Stage register frees up when empty or when the queue takes its token
    assign req.ready = !valid_reg || tok_ready;
    assign take      = req.valid && req.ready;

    // Byte classification
    always_comb
    begin
        tok_next.data      = req.in_byte;
        tok_next.is_digit  = (req.in_byte >= rapu_pkg::CH_ZERO) &&
                             (req.in_byte <= rapu_pkg::CH_NINE);
        tok_next.is_cr     = (req.in_byte == rapu_pkg::CH_CR);
        tok_next.is_lf     = (req.in_byte == rapu_pkg::CH_LF);
        tok_next.is_star   = (req.in_byte == rapu_pkg::CH_STAR);
        tok_next.is_dollar = (req.in_byte == rapu_pkg::CH_DOLLAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

>>> rtl/core/rapu_fifo.sv
// Short token queue decoupling the classifier from the parser.
// Depends on rapu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "resp_array_parser_unit_macros.svh"

module rapu_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  rapu_pkg::token_t  push_tok,
    output logic              push_ready,
    output logic              pop_valid,
    output rapu_pkg::token_t  pop_tok,
    input  logic              pop_ready
);

    rapu_pkg::token_t                 mem_reg [rapu_pkg::FIFO_DEPTH];
    logic [rapu_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [rapu_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [rapu_pkg::FIFO_AW:0]       count_reg;
    logic [rapu_pkg::FIFO_AW:0]       count_next;
    logic                             push;
    logic                             pop;

    assign push_ready = (count_reg != (rapu_pkg::FIFO_AW + 1)'(rapu_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = mem_reg[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    `RAPU_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= (rapu_pkg::FIFO_AW + 1)'(rapu_pkg::FIFO_DEPTH), "queue count beyond depth")
    `RAPU_ASSERT_NXT(a_push_only, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "push without pop did not grow queue")
    `RAPU_ASSERT_IMP(a_ptr_gap, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with pointer gap")

endmodule

>>> rtl/core/rapu_back.sv
// Back end: framing state machine that consumes tokens and registers results.
// Depends on rapu_pkg, rapu_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "resp_array_parser_unit_macros.svh"

module rapu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rapu_pkg::cfg_t    cfg,
    input  logic              tok_valid,
    input  rapu_pkg::token_t  tok,
    output logic              tok_ready,
    rapu_out_if.source        rsp
);

    rapu_pkg::phase_t   phase_reg,  phase_next;
    logic [5:0]         total_reg,  total_next;
    logic [5:0]         num_reg,    num_next;
    logic [16:0]        acc_reg,    acc_next;
    logic [15:0]        remain_reg, remain_next;
    logic [15:0]        plen_reg,   plen_next;
    logic               out_valid_reg;
    rapu_pkg::result_t  out_reg;

    logic               take;
    logic               emit;
    rapu_pkg::result_t  res;
    logic [20:0]        acc_mul;
    logic [16:0]        acc_sat;
    logic [5:0]         arg_lim;
    logic               is_last;

    // Output register frees up when empty or when the sink takes its beat
    assign tok_ready = !out_valid_reg || rsp.ready;
    assign take      = tok_valid && tok_ready;

    // Decimal accumulate with saturation
    assign acc_mul = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {17'd0, tok.data[3:0]};
    assign acc_sat = (acc_mul > {4'd0, rapu_pkg::NUM_MAX}) ? rapu_pkg::NUM_MAX : acc_mul[16:0];

    assign arg_lim = (cfg.args_limit < rapu_pkg::ARG_LIMIT) ? cfg.args_limit
                                                            : rapu_pkg::ARG_LIMIT;
    assign is_last = ({1'b0, num_reg} + 7'd1) >= {1'b0, total_reg};

    // Next state and result for the token at the head of the queue
    always_comb
    begin
        phase_next  = phase_reg;
        total_next  = total_reg;
        num_next    = num_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        plen_next   = plen_reg;
        emit        = 1'b0;
        res         = '0;

        unique case (phase_reg)
            rapu_pkg::PH_CNT, rapu_pkg::PH_LEN:
            begin
                if (tok.is_cr)
                begin
                    phase_next = (phase_reg == rapu_pkg::PH_CNT) ? rapu_pkg::PH_CNT_LF
                                                                 : rapu_pkg::PH_LEN_LF;
                end
                else if (!tok.is_digit)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_NON_DIGIT;
                end
                else
                begin
                    acc_next = acc_sat;
                end
            end
            rapu_pkg::PH_CNT_LF:
            begin
                if (!tok.is_lf)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_BAD_TERM;
                end
                else if (acc_reg > {11'd0, arg_lim})
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_TOO_MANY;
                end
                else if (acc_reg == '0)
                begin
                    phase_next = rapu_pkg::PH_HDR;
                end
                else
                begin
                    total_next = acc_reg[5:0];
                    num_next   = '0;
                    acc_next   = '0;
                    phase_next = rapu_pkg::PH_DOLLAR;
                end
            end
            rapu_pkg::PH_DOLLAR:
            begin
                if (!tok.is_dollar)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_NO_DOLLAR;
                end
                else
                begin
                    acc_next   = '0;
                    phase_next = rapu_pkg::PH_LEN;
                end
            end
            rapu_pkg::PH_LEN_LF:
            begin
                if (!tok.is_lf)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_BAD_TERM;
                end
                else if ((acc_reg > {1'b0, cfg.max_len}) || (acc_reg >= rapu_pkg::LENGTH_LIMIT))
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_TOO_LONG;
                end
                else
                begin
                    plen_next   = acc_reg[15:0];
                    remain_next = acc_reg[15:0];
                    acc_next    = '0;
                    phase_next  = (acc_reg == '0) ? rapu_pkg::PH_DATA_CR : rapu_pkg::PH_DATA;
                end
            end
            rapu_pkg::PH_DATA:
            begin
                emit          = 1'b1;
                res.kind      = rapu_pkg::RK_PAYLOAD;
                res.data_byte = tok.data;
                res.arg_index = num_reg[4:0];
                remain_next   = remain_reg - 1'b1;
                if (remain_reg == 16'd1)
                begin
                    phase_next = rapu_pkg::PH_DATA_CR;
                end
            end
            rapu_pkg::PH_DATA_CR:
            begin
                if (!tok.is_cr)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_BAD_TERM;
                end
                else
                begin
                    phase_next = rapu_pkg::PH_DATA_LF;
                end
            end
            rapu_pkg::PH_DATA_LF:
            begin
                if (!tok.is_lf)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_BAD_TERM;
                end
                else
                begin
                    emit           = 1'b1;
                    res.kind       = rapu_pkg::RK_ARG_END;
                    res.arg_index  = num_reg[4:0];
                    res.arg_length = plen_reg;
                    res.last       = is_last;
                    if (is_last)
                    begin
                        phase_next = rapu_pkg::PH_HDR;
                    end
                    else
                    begin
                        num_next   = num_reg + 1'b1;
                        plen_next  = '0;
                        phase_next = rapu_pkg::PH_DOLLAR;
                    end
                end
            end
            default:
            begin
                // Array header, also unused phase codes
                if (!tok.is_star)
                begin
                    emit     = 1'b1;
                    res.kind = rapu_pkg::RK_ERROR;
                    res.code = rapu_pkg::ERR_BAD_HEADER;
                end
                else
                begin
                    total_next  = '0;
                    num_next    = '0;
                    acc_next    = '0;
                    remain_next = '0;
                    plen_next   = '0;
                    phase_next  = rapu_pkg::PH_CNT;
                end
            end
        endcase

        // Errors, end of command and empty commands drop all parse state
        if ((emit && (res.kind == rapu_pkg::RK_ERROR)) || (phase_next == rapu_pkg::PH_HDR))
        begin
            phase_next  = rapu_pkg::PH_HDR;
            total_next  = '0;
            num_next    = '0;
            acc_next    = '0;
            remain_next = '0;
            plen_next   = '0;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= rapu_pkg::PH_HDR;
            total_reg  <= '0;
            num_reg    <= '0;
            acc_reg    <= '0;
            remain_reg <= '0;
            plen_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            total_reg  <= total_next;
            num_reg    <= num_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            plen_reg   <= plen_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tok_ready)
        begin
            out_valid_reg <= take && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.result_kind     = out_reg.kind;
    assign rsp.data_byte       = out_reg.data_byte;
    assign rsp.arg_index       = out_reg.arg_index;
    assign rsp.arg_length      = out_reg.arg_length;
    assign rsp.last_of_command = out_reg.last;
    assign rsp.error_code      = out_reg.code;

    `RAPU_ASSERT_NXT(a_err_restart, clk, rst_n,
        take && emit && (res.kind == rapu_pkg::RK_ERROR),
        phase_reg == rapu_pkg::PH_HDR, "error did not restart at header")
    `RAPU_ASSERT_IMP(a_data_remain, clk, rst_n,
        phase_reg == rapu_pkg::PH_DATA,
        remain_reg != '0, "payload phase with nothing left")
    `RAPU_ASSERT_IMP(a_last_is_end, clk, rst_n,
        rsp.valid && rsp.last_of_command,
        rsp.result_kind == rapu_pkg::RK_ARG_END, "last flag on non end beat")
    `RAPU_ASSERT_IMP(a_num_below_total, clk, rst_n,
        phase_reg == rapu_pkg::PH_DATA_LF,
        num_reg < total_reg, "argument number past total")

endmodule

>>> rtl/core/resp_array_parser_unit.sv
// Top level of the array-framed request parser: config registers, front, queue, back.
// Depends on rapu_pkg, rapu_in_if, rapu_out_if, rapu_front, rapu_fifo, rapu_back.
`timescale 1ns / 1ps

// Parses '*' count CRLF, then per argument '$' length CRLF payload CRLF, one byte
// per beat, and emits a payload beat per payload byte, an end beat per argument
// (with its length and a last flag) and an error beat on any framing fault, after
// which parsing restarts at the header. It sustains one request byte per cycle
// while the output is not stalled: the classifier register, a four-entry token
// queue and the result register each pass one token a cycle. The result beat for
// a byte passes through the classifier register, then the queue, then the result
// register, and is held there until the output takes it. Write max_arguments
// (index 0) and max_argument_length (index 1) only while no bytes are in flight.
module resp_array_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    rapu_in_if.sink     req,
    rapu_out_if.source  rsp
);

    logic [5:0]         args_limit_reg;
    logic [15:0]        max_len_reg;
    rapu_pkg::cfg_t     cfg;
    logic               f_valid;
    rapu_pkg::token_t   f_tok;
    logic               f_ready;
    logic               q_valid;
    rapu_pkg::token_t   q_tok;
    logic               q_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            args_limit_reg <= rapu_pkg::MAX_ARGS_RST;
            max_len_reg    <= rapu_pkg::MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (rapu_pkg::cfg_reg_t'(cfg_index))
                rapu_pkg::CFG_MAX_ARGS: args_limit_reg <= cfg_wdata[5:0];
                rapu_pkg::CFG_MAX_LEN:  max_len_reg    <= cfg_wdata;
                default:                max_len_reg    <= max_len_reg;
            endcase
        end
    end

    assign cfg.args_limit = args_limit_reg;
    assign cfg.max_len    = max_len_reg;

    rapu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .tok_valid (f_valid),
        .tok       (f_tok),
        .tok_ready (f_ready)
    );

    rapu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_tok   (f_tok),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_tok    (q_tok),
        .pop_ready  (q_ready)
    );

    rapu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tok_valid (q_valid),
        .tok       (q_tok),
        .tok_ready (q_ready),
        .rsp       (rsp)
    );

endmodule

>>> bench/rapu_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the array request parser: tracks the parse on every accepted
// request beat and compares each result beat, in order, with what it predicts.
// Depends on rapu_pkg, rapu_in_if and rapu_out_if.

module rapu_result_checker
    import rapu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    rapu_in_if          req,
    rapu_out_if         rsp,
    output int          fail_count,
    output int          pending,
    output int          payload_beats,
    output int          end_beats,
    output int          error_beats
);

    // Limits as last written
    logic [5:0]  lim_args = MAX_ARGS_RST;
    logic [15:0] lim_len  = MAX_LEN_RST;

    // Parse state
    phase_t      phase     = PH_HDR;
    logic [5:0]  arg_total = '0;
    logic [5:0]  arg_num   = '0;
    logic [16:0] acc       = '0;
    logic [16:0] remaining = '0;
    logic [16:0] plen      = '0;

    // Results predicted but not yet seen on the output
    result_t     expected_q[$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        payload_beats = 0;
        end_beats     = 0;
        error_beats   = 0;
    end

    function automatic void restart_parse();
        phase     = PH_HDR;
        arg_total = '0;
        arg_num   = '0;
        acc       = '0;
        remaining = '0;
        plen      = '0;
    endfunction

    // Any framing fault: one error beat, then back to the header
    function automatic result_t framing_error(err_code_t code);
        result_t r;
        restart_parse();
        r      = '0;
        r.kind = RK_ERROR;
        r.code = code;
        return r;
    endfunction

    // Advance the parse by one byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        logic       is_digit;
        logic [5:0] arg_cap;
        int         grown;
        logic       is_last;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        r = '0;
        case (phase)
            PH_CNT, PH_LEN: begin
                if (b == CH_CR) begin
                    phase = (phase == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
                    return 1'b0;
                end
                if (!is_digit) begin
                    r = framing_error(ERR_NON_DIGIT);
                    return 1'b1;
                end
                // decimal accumulate, saturating
                grown = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
                acc = (grown > int'(NUM_MAX)) ? NUM_MAX : grown[16:0];
                return 1'b0;
            end
            PH_CNT_LF: begin
                if (b != CH_LF) begin
                    r = framing_error(ERR_BAD_TERM);
                    return 1'b1;
                end
                arg_cap = (lim_args < ARG_LIMIT) ? lim_args : ARG_LIMIT;
                if (acc > {11'd0, arg_cap}) begin
                    r = framing_error(ERR_TOO_MANY);
                    return 1'b1;
                end
                // empty command: skipped without output
                if (acc == '0) begin
                    restart_parse();
                    return 1'b0;
                end
                arg_total = acc[5:0];
                arg_num   = '0;
                acc       = '0;
                phase     = PH_DOLLAR;
                return 1'b0;
            end
            PH_DOLLAR: begin
                if (b != CH_DOLLAR) begin
                    r = framing_error(ERR_NO_DOLLAR);
                    return 1'b1;
                end
                acc   = '0;
                phase = PH_LEN;
                return 1'b0;
            end
            PH_LEN_LF: begin
                if (b != CH_LF) begin
                    r = framing_error(ERR_BAD_TERM);
                    return 1'b1;
                end
                if (acc > {1'b0, lim_len} || acc >= LENGTH_LIMIT) begin
                    r = framing_error(ERR_TOO_LONG);
                    return 1'b1;
                end
                plen      = acc;
                remaining = acc;
                acc       = '0;
                phase     = (remaining == '0) ? PH_DATA_CR : PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                r.kind      = RK_PAYLOAD;
                r.data_byte = b;
                r.arg_index = arg_num[4:0];
                remaining   = remaining - 17'd1;
                if (remaining == '0) phase = PH_DATA_CR;
                return 1'b1;
            end
            PH_DATA_CR: begin
                if (b != CH_CR) begin
                    r = framing_error(ERR_BAD_TERM);
                    return 1'b1;
                end
                phase = PH_DATA_LF;
                return 1'b0;
            end
            PH_DATA_LF: begin
                if (b != CH_LF) begin
                    r = framing_error(ERR_BAD_TERM);
                    return 1'b1;
                end
                is_last      = ({1'b0, arg_num} + 7'd1) >= {1'b0, arg_total};
                r.kind       = RK_ARG_END;
                r.arg_index  = arg_num[4:0];
                r.arg_length = plen[15:0];
                r.last       = is_last;
                if (is_last) begin
                    restart_parse();
                end else begin
                    arg_num = arg_num + 6'd1;
                    plen    = '0;
                    phase   = PH_DOLLAR;
                end
                return 1'b1;
            end
            default: begin
                if (b != CH_STAR) begin
                    r = framing_error(ERR_BAD_HEADER);
                    return 1'b1;
                end
                restart_parse();
                phase = PH_CNT;
                return 1'b0;
            end
        endcase
    endfunction

    // Watch the channels at each edge; results are matched before the byte of
    // the same edge is predicted, so a beat never meets its own byte
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t fresh;
        if (!rst_n) begin
            restart_parse();
            lim_args = MAX_ARGS_RST;
            lim_len  = MAX_LEN_RST;
            expected_q.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                case (rsp.result_kind)
                    RK_PAYLOAD: payload_beats++;
                    RK_ARG_END: end_beats++;
                    default:    error_beats++;
                endcase
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat kind=%0d data=%02h idx=%0d len=%0d err=%0d",
                             $time, rsp.result_kind, rsp.data_byte, rsp.arg_index,
                             rsp.arg_length, rsp.error_code);
                end else begin
                    want = expected_q.pop_front();
                    if (rsp.result_kind !== want.kind || rsp.data_byte !== want.data_byte ||
                        rsp.arg_index !== want.arg_index || rsp.arg_length !== want.arg_length ||
                        rsp.last_of_command !== want.last || rsp.error_code !== want.code) begin
                        fail_count++;
                        $display("%0t: mismatch exp kind=%0d data=%02h idx=%0d len=%0d last=%0b err=%0d",
                                 $time, want.kind, want.data_byte, want.arg_index,
                                 want.arg_length, want.last, want.code);
                        $display("          got kind=%0d data=%02h idx=%0d len=%0d last=%0b err=%0d",
                                 rsp.result_kind, rsp.data_byte, rsp.arg_index,
                                 rsp.arg_length, rsp.last_of_command, rsp.error_code);
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_MAX_ARGS) lim_args = cfg_wdata[5:0];
                else lim_len = cfg_wdata;
            end
            if (req.valid && req.ready) begin
                if (parse_byte(req.in_byte, fresh)) expected_q.push_back(fresh);
            end
        end
        pending = expected_q.size();
    end

endmodule

>>> bench/tb_resp_array_parser_unit.sv
`timescale 1ns / 1ps
// Testbench top for resp_array_parser_unit: drives request beats and limit writes,
// stalls the result side, and reports the verdict from rapu_result_checker.
// Depends on rapu_pkg, rapu_in_if, rapu_out_if, the parser RTL and the checker.

module tb_resp_array_parser_unit;
    import rapu_pkg::*;

    localparam int NUM_PHASES = 5;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;

    rapu_in_if  req();
    rapu_out_if rsp();

    int fail_count;
    int pending;
    int payload_beats;
    int end_beats;
    int error_beats;

    // Limit settings per phase, extremes included
    int phase_args[NUM_PHASES]   = '{32, 1, 0, 63, 5};
    int phase_len[NUM_PHASES]    = '{8191, 65535, 0, 16, 7};
    int phase_bytes[NUM_PHASES]  = '{260, 230, 120, 330, 240};
    int phase_odds[NUM_PHASES]   = '{4, 8, 3, 6, 0};

    logic [7:0]  byte_stream[$];
    logic [5:0]  set_args;
    logic [15:0] set_len;
    int          idle_odds;
    bit          long_hold;
    int          bytes_sent;

    resp_array_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    rapu_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending),
        .payload_beats (payload_beats),
        .end_beats     (end_beats),
        .error_beats   (error_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #1_000_000;
        $display("Timeout: parser made no progress, %0d results outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stall bursts, and one long hold-off on request
    initial
    begin
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic push_text(string s);
        foreach (s[i]) byte_stream.push_back(s[i]);
    endtask

    task automatic push_crlf();
        byte_stream.push_back(CH_CR);
        byte_stream.push_back(CH_LF);
    endtask

    task automatic push_number(int unsigned value);
        // an empty digit string reads as zero
        if (value == 0 && $urandom_range(0, 3) == 0) return;
        if ($urandom_range(0, 9) == 0) byte_stream.push_back(CH_ZERO);
        push_text($sformatf("%0d", value));
    endtask

    // Bytes biased toward the framing characters
    function automatic logic [7:0] framing_byte();
        case ($urandom_range(0, 5))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_DOLLAR;
            3:       return CH_STAR;
            4:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One request, mostly well formed, sized to the limits in force
    task automatic add_command();
        int base;
        int pos;
        int count;
        int arg_cap;
        int len_cap;
        int len;
        int roll;
        bit cut;
        base    = byte_stream.size();
        arg_cap = (set_args < ARG_LIMIT) ? int'(set_args) : int'(ARG_LIMIT);
        len_cap = (int'(set_len) < int'(LENGTH_LIMIT) - 1) ? int'(set_len)
                                                           : int'(LENGTH_LIMIT) - 1;
        // stray bytes between requests
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 3)) byte_stream.push_back(framing_byte());
            return;
        end
        roll = $urandom_range(0, 99);
        if (arg_cap == 0)   count = $urandom_range(0, 3);
        else if (roll < 6)  count = arg_cap + $urandom_range(1, 3);
        else if (roll < 9)  count = 0;
        else if (roll < 12) count = arg_cap;
        else                count = $urandom_range(1, (arg_cap < 4) ? arg_cap : 4);
        byte_stream.push_back(CH_STAR);
        // an oversized count sometimes given with enough digits to saturate
        if (count > arg_cap && $urandom_range(0, 3) == 0) push_text("999999");
        else push_number(count);
        push_crlf();
        cut = (count == 0) || (count > arg_cap);
        for (int k = 0; k < count && !cut; k++)
        begin
            byte_stream.push_back(CH_DOLLAR);
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                push_number(len_cap + 1 + $urandom_range(0, 2));
                push_crlf();
                cut = 1'b1;
            end
            else if (roll < 5)
            begin
                push_text("9999999");
                push_crlf();
                cut = 1'b1;
            end
            else
            begin
                if (roll < 12)                       len = $urandom_range(0, (len_cap < 40) ? len_cap : 40);
                else if (roll < 14 && len_cap <= 64) len = len_cap;
                else                                 len = $urandom_range(0, (len_cap < 8) ? len_cap : 8);
                push_number(len);
                push_crlf();
                repeat (len) byte_stream.push_back(8'($urandom_range(0, 255)));
                push_crlf();
            end
        end
        // broken request: one byte replaced, the rest dropped
        if ($urandom_range(0, 9) == 0)
        begin
            pos = $urandom_range(base, byte_stream.size() - 1);
            byte_stream[pos] = framing_byte();
            while (byte_stream.size() > pos + 1) void'(byte_stream.pop_back());
        end
    endtask

    // Offer every queued byte, with random gaps
    task automatic send_stream();
        while (byte_stream.size() > 0)
        begin
            if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            req.valid   <= 1'b1;
            req.in_byte <= byte_stream.pop_front();
            @(posedge clk);
            while (!req.ready) @(posedge clk);
            bytes_sent++;
        end
        req.valid <= 1'b0;
    endtask

    // Wait for every predicted beat, then let in-flight bytes that yield nothing clear
    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limits(int args, int len);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_ARGS;
        cfg_wdata <= 16'(args);
        @(posedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_wdata <= 16'(len);
        @(posedge clk);
        cfg_we   <= 1'b0;
        set_args = 6'(args);
        set_len  = 16'(len);
    endtask

    // Stimulus
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_MAX_ARGS;
        cfg_wdata   = '0;
        req.valid   = 1'b0;
        req.in_byte = '0;
        rsp.ready   = 1'b0;
        set_args    = MAX_ARGS_RST;
        set_len     = MAX_LEN_RST;
        idle_odds   = 0;
        long_hold   = 1'b0;
        bytes_sent  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limits(phase_args[p], phase_len[p]);
            idle_odds = phase_odds[p];
            if (p == 0)
            begin
                // two arguments, the first empty, payload at both byte extremes
                push_text("*2");
                push_crlf();
                push_text("$0");
                push_crlf();
                push_crlf();
                push_text("$2");
                push_crlf();
                byte_stream.push_back(8'h00);
                byte_stream.push_back(8'hFF);
                push_crlf();
                // bad header, empty count, non-digit, missing dollar
                push_text("Z*");
                push_crlf();
                push_text("*x*1");
                push_crlf();
                push_text("#");
            end
            while (byte_stream.size() < phase_bytes[p]) add_command();
            // fill the block against a stalled output once
            if (p == 0) long_hold = 1'b1;
            send_stream();
            wait_drained();
        end

        $display("Sent %0d request bytes under %0d limit settings, with one long output stall.",
                 bytes_sent, NUM_PHASES);
        $display("Checked %0d payload, %0d argument-end and %0d error beats.",
                 payload_beats, end_beats, error_beats);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
